### hw/rtl/orot_pkg.sv
// orot_pkg: widths, item codes, types and arithmetic helpers for the
// oriented rectangle overlap test. No dependencies.
`timescale 1ns / 1ps

package orot_pkg;

    // coordinate width of one input field, signed Q11.4 at 16 bits
    localparam int COORD_WIDTH = 16;
    // world corner = corner + body
    localparam int WORLD_W     = COORD_WIDTH + 1;
    // axis = difference of two world corners
    localparam int AXIS_W      = COORD_WIDTH + 2;
    // one product corner * axis component
    localparam int PROD_W      = WORLD_W + AXIS_W;
    // dot product = sum of two products
    localparam int DOT_W       = PROD_W + 1;

    localparam int N_CORNERS   = 4;
    localparam int N_AXES      = 4;

    // corner slots
    localparam int C_UR = 0;
    localparam int C_UL = 1;
    localparam int C_LR = 2;
    localparam int C_LL = 3;

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [WORLD_W-1:0]     world_t;
    typedef logic signed [AXIS_W-1:0]      axis_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [DOT_W-1:0]       dot_t;

    // exact projection of one corner onto one axis
    function automatic dot_t dot(world_t px, world_t py, axis_t ax, axis_t ay);
        prod_t p0;
        prod_t p1;
        p0 = px * ax;
        p1 = py * ay;
        return dot_t'(p0) + dot_t'(p1);
    endfunction

    // smaller / larger of two projections
    function automatic dot_t dmin(dot_t a, dot_t b);
        return (a <= b) ? a : b;
    endfunction

    function automatic dot_t dmax(dot_t a, dot_t b);
        return (a >= b) ? a : b;
    endfunction

endpackage

### hw/rtl/oriented_rect_overlap_test.sv
// oriented_rect_overlap_test: separating-axis overlap test of two oriented
// rectangles, five register stages. Depends on orot_pkg.
`timescale 1ns / 1ps

// A transaction is taken at every clock edge with start high; busy is always
// low, so one load or test enters per cycle. A load (cmd 0) stores rectangle A
// and gives no result. A test (cmd 1) gives overlap with done high for one
// cycle per test, after passing from the input register through each later
// register in order (world corners, axes, 32 registered dot products, min/max
// and interval compare).
// The receiver cannot stall the block, so it must take done whenever it rises.
// A test sees every load taken before it, even one taken in the cycle just
// before. Touching rectangles count as overlapping; before any load, A is a
// rectangle collapsed onto the origin.
module oriented_rect_overlap_test
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  orot_pkg::coord_t     upper_right_x,
    input  orot_pkg::coord_t     upper_right_y,
    input  orot_pkg::coord_t     upper_left_x,
    input  orot_pkg::coord_t     upper_left_y,
    input  orot_pkg::coord_t     lower_right_x,
    input  orot_pkg::coord_t     lower_right_y,
    input  orot_pkg::coord_t     lower_left_x,
    input  orot_pkg::coord_t     lower_left_y,
    input  orot_pkg::coord_t     body_x,
    input  orot_pkg::coord_t     body_y,
    output logic                 done,
    output logic                 overlap
);

    // stage 1: input register
    logic                 v1_reg;
    logic                 cmd_reg;
    orot_pkg::coord_t     in_x_reg  [orot_pkg::N_CORNERS];
    orot_pkg::coord_t     in_y_reg  [orot_pkg::N_CORNERS];
    orot_pkg::coord_t     in_x_next [orot_pkg::N_CORNERS];
    orot_pkg::coord_t     in_y_next [orot_pkg::N_CORNERS];
    orot_pkg::coord_t     body_x_reg;
    orot_pkg::coord_t     body_y_reg;

    // stored rectangle A
    orot_pkg::world_t     st_x_reg  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     st_y_reg  [orot_pkg::N_CORNERS];

    // stage 2: world corners of A and B
    logic                 v2_reg;
    logic                 v2_next;
    logic                 load_hit;
    orot_pkg::world_t     w_x_next  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     w_y_next  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     a2_x_reg  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     a2_y_reg  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     b2_x_reg  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     b2_y_reg  [orot_pkg::N_CORNERS];

    // stage 3: axes plus corners
    logic                 v3_reg;
    orot_pkg::axis_t      ax_next   [orot_pkg::N_AXES];
    orot_pkg::axis_t      ay_next   [orot_pkg::N_AXES];
    orot_pkg::axis_t      ax_reg    [orot_pkg::N_AXES];
    orot_pkg::axis_t      ay_reg    [orot_pkg::N_AXES];
    orot_pkg::world_t     a3_x_reg  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     a3_y_reg  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     b3_x_reg  [orot_pkg::N_CORNERS];
    orot_pkg::world_t     b3_y_reg  [orot_pkg::N_CORNERS];

    // stage 4: projections, [axis][corner]
    logic                 v4_reg;
    orot_pkg::dot_t       da_next   [orot_pkg::N_AXES][orot_pkg::N_CORNERS];
    orot_pkg::dot_t       db_next   [orot_pkg::N_AXES][orot_pkg::N_CORNERS];
    orot_pkg::dot_t       da_reg    [orot_pkg::N_AXES][orot_pkg::N_CORNERS];
    orot_pkg::dot_t       db_reg    [orot_pkg::N_AXES][orot_pkg::N_CORNERS];

    // stage 5: result
    logic                 done_reg;
    logic                 overlap_reg;
    logic                 overlap_next;

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign overlap = overlap_reg;

    // input corner ordering: UR, UL, LR, LL
    always_comb
    begin
        in_x_next[orot_pkg::C_UR] = upper_right_x;
        in_y_next[orot_pkg::C_UR] = upper_right_y;
        in_x_next[orot_pkg::C_UL] = upper_left_x;
        in_y_next[orot_pkg::C_UL] = upper_left_y;
        in_x_next[orot_pkg::C_LR] = lower_right_x;
        in_y_next[orot_pkg::C_LR] = lower_right_y;
        in_x_next[orot_pkg::C_LL] = lower_left_x;
        in_y_next[orot_pkg::C_LL] = lower_left_y;
    end

    // world corners and load decode
    always_comb
    begin
        for (int k = 0; k < orot_pkg::N_CORNERS; k++)
        begin
            w_x_next[k] = orot_pkg::world_t'(in_x_reg[k])
                        + orot_pkg::world_t'(body_x_reg);
            w_y_next[k] = orot_pkg::world_t'(in_y_reg[k])
                        + orot_pkg::world_t'(body_y_reg);
        end
        load_hit = v1_reg && (cmd_reg == orot_pkg::CMD_LOAD);
        v2_next  = v1_reg && (cmd_reg == orot_pkg::CMD_TEST);
    end

    // edge axes: A's UR-UL and UR-LR, B's UL-LL and UL-UR
    always_comb
    begin
        ax_next[0] = orot_pkg::axis_t'(a2_x_reg[orot_pkg::C_UR])
                   - orot_pkg::axis_t'(a2_x_reg[orot_pkg::C_UL]);
        ay_next[0] = orot_pkg::axis_t'(a2_y_reg[orot_pkg::C_UR])
                   - orot_pkg::axis_t'(a2_y_reg[orot_pkg::C_UL]);
        ax_next[1] = orot_pkg::axis_t'(a2_x_reg[orot_pkg::C_UR])
                   - orot_pkg::axis_t'(a2_x_reg[orot_pkg::C_LR]);
        ay_next[1] = orot_pkg::axis_t'(a2_y_reg[orot_pkg::C_UR])
                   - orot_pkg::axis_t'(a2_y_reg[orot_pkg::C_LR]);
        ax_next[2] = orot_pkg::axis_t'(b2_x_reg[orot_pkg::C_UL])
                   - orot_pkg::axis_t'(b2_x_reg[orot_pkg::C_LL]);
        ay_next[2] = orot_pkg::axis_t'(b2_y_reg[orot_pkg::C_UL])
                   - orot_pkg::axis_t'(b2_y_reg[orot_pkg::C_LL]);
        ax_next[3] = orot_pkg::axis_t'(b2_x_reg[orot_pkg::C_UL])
                   - orot_pkg::axis_t'(b2_x_reg[orot_pkg::C_UR]);
        ay_next[3] = orot_pkg::axis_t'(b2_y_reg[orot_pkg::C_UL])
                   - orot_pkg::axis_t'(b2_y_reg[orot_pkg::C_UR]);
    end

    // project every corner of both rectangles on every axis
    always_comb
    begin
        for (int i = 0; i < orot_pkg::N_AXES; i++)
        begin
            for (int k = 0; k < orot_pkg::N_CORNERS; k++)
            begin
                da_next[i][k] = orot_pkg::dot(a3_x_reg[k], a3_y_reg[k],
                                              ax_reg[i], ay_reg[i]);
                db_next[i][k] = orot_pkg::dot(b3_x_reg[k], b3_y_reg[k],
                                              ax_reg[i], ay_reg[i]);
            end
        end
    end

    // interval min/max per axis and separation check
    always_comb
    begin
        orot_pkg::dot_t amin;
        orot_pkg::dot_t amax;
        orot_pkg::dot_t bmin;
        orot_pkg::dot_t bmax;
        overlap_next = 1'b1;
        for (int i = 0; i < orot_pkg::N_AXES; i++)
        begin
            amin = orot_pkg::dmin(orot_pkg::dmin(da_reg[i][0], da_reg[i][1]),
                                  orot_pkg::dmin(da_reg[i][2], da_reg[i][3]));
            amax = orot_pkg::dmax(orot_pkg::dmax(da_reg[i][0], da_reg[i][1]),
                                  orot_pkg::dmax(da_reg[i][2], da_reg[i][3]));
            bmin = orot_pkg::dmin(orot_pkg::dmin(db_reg[i][0], db_reg[i][1]),
                                  orot_pkg::dmin(db_reg[i][2], db_reg[i][3]));
            bmax = orot_pkg::dmax(orot_pkg::dmax(db_reg[i][0], db_reg[i][1]),
                                  orot_pkg::dmax(db_reg[i][2], db_reg[i][3]));
            if (!((bmin <= amax) && (amin <= bmax)))
            begin
                overlap_next = 1'b0;
            end
        end
    end

    // pipeline valids and stored rectangle A
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k < orot_pkg::N_CORNERS; k++)
            begin
                st_x_reg[k] <= '0;
                st_y_reg[k] <= '0;
            end
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v2_next;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
            if (load_hit)
            begin
                for (int k = 0; k < orot_pkg::N_CORNERS; k++)
                begin
                    st_x_reg[k] <= w_x_next[k];
                    st_y_reg[k] <= w_y_next[k];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg    <= cmd;
            body_x_reg <= body_x;
            body_y_reg <= body_y;
            for (int k = 0; k < orot_pkg::N_CORNERS; k++)
            begin
                in_x_reg[k] <= in_x_next[k];
                in_y_reg[k] <= in_y_next[k];
            end
        end
        if (v2_next)
        begin
            for (int k = 0; k < orot_pkg::N_CORNERS; k++)
            begin
                a2_x_reg[k] <= st_x_reg[k];
                a2_y_reg[k] <= st_y_reg[k];
                b2_x_reg[k] <= w_x_next[k];
                b2_y_reg[k] <= w_y_next[k];
            end
        end
        if (v2_reg)
        begin
            for (int k = 0; k < orot_pkg::N_CORNERS; k++)
            begin
                a3_x_reg[k] <= a2_x_reg[k];
                a3_y_reg[k] <= a2_y_reg[k];
                b3_x_reg[k] <= b2_x_reg[k];
                b3_y_reg[k] <= b2_y_reg[k];
            end
            for (int i = 0; i < orot_pkg::N_AXES; i++)
            begin
                ax_reg[i] <= ax_next[i];
                ay_reg[i] <= ay_next[i];
            end
        end
        if (v3_reg)
        begin
            for (int i = 0; i < orot_pkg::N_AXES; i++)
            begin
                for (int k = 0; k < orot_pkg::N_CORNERS; k++)
                begin
                    da_reg[i][k] <= da_next[i][k];
                    db_reg[i][k] <= db_next[i][k];
                end
            end
        end
        if (v4_reg)
        begin
            overlap_reg <= overlap_next;
        end
    end

endmodule
